@@ design/aes256_block_encrypt_top_defines.svh @@
// Assertion macros used by the block's checker
`ifndef AES256_BLOCK_ENCRYPT_TOP_DEFINES_SVH
`define AES256_BLOCK_ENCRYPT_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define AES_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

@@ design/aes_pkg.sv @@
// AES-256 package: types, S-box and round helpers
`timescale 1ns / 1ps
package aes_pkg;
	localparam int unsigned BLOCK_W = 128;
	localparam int unsigned WORD_W = 64;
	localparam int unsigned KEY_REGS = 4;
	localparam int unsigned ROUNDS = 14;
	localparam logic [1:0] REG_KEY0 = 2'd0;
	localparam logic [1:0] REG_KEY1 = 2'd1;
	localparam logic [1:0] REG_KEY2 = 2'd2;
	localparam logic [1:0] REG_KEY3 = 2'd3;
	localparam logic [7:0] RCON_INIT = 8'h01;
	localparam logic [7:0] XTIME_POLY = 8'h1b;

	typedef logic [BLOCK_W-1:0] block_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [1:0] reg_idx_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// byte n of a block sits at bits 127-8n : 120-8n
	function automatic logic [7:0] get_byte(input block_t b, input int n);
		return b[BLOCK_W-1-8*n -: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? XTIME_POLY : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic block_t sub_shift(input block_t s);
		block_t t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[BLOCK_W-1-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
		return t;
	endfunction

	function automatic block_t mix_columns(input block_t s);
		block_t t;
		logic [7:0] a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c);
			a1 = get_byte(s, 4*c+1);
			a2 = get_byte(s, 4*c+2);
			a3 = get_byte(s, 4*c+3);
			all = a0 ^ a1 ^ a2 ^ a3;
			t[BLOCK_W-1-8*(4*c) -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[BLOCK_W-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[BLOCK_W-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[BLOCK_W-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction
endpackage

@@ design/aes_stream_if.sv @@
// Valid/ready channel carrying one 128-bit block as two 64-bit halves
`timescale 1ns / 1ps
interface aes_stream_if;
	logic valid;
	logic ready;
	logic [63:0] data_high;
	logic [63:0] data_low;
	modport source (output valid, output data_high, output data_low, input ready);
	modport sink (input valid, input data_high, input data_low, output ready);
endinterface

@@ design/aes_key_sched.sv @@
// AES-256 key expansion: one schedule step per cycle after a key write or reset
`timescale 1ns / 1ps
module aes_key_sched (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input aes_pkg::reg_idx_t cfg_idx,
	input aes_pkg::word_t cfg_data,
	output logic busy,
	output aes_pkg::block_t round_key [aes_pkg::ROUNDS+1]
);
	import aes_pkg::*;

	// 60 schedule words, held as 15 round keys; rebuilt one word per step
	localparam int unsigned SCHED_WORDS = 4 * (ROUNDS + 1);
	localparam int unsigned STEP_W = $clog2(SCHED_WORDS);

	logic [255:0] key_q;
	logic [255:0] key_d;
	logic [31:0] w_q [SCHED_WORDS];
	// last eight schedule words, oldest at index 0
	logic [31:0] win_q [8];
	logic [STEP_W-1:0] idx_q;
	logic [7:0] rcon_q;
	logic busy_q;
	logic [31:0] t, nw;

	always_comb begin
		key_d = key_q;
		unique case (cfg_idx)
			REG_KEY0: key_d[255:192] = cfg_data;
			REG_KEY1: key_d[191:128] = cfg_data;
			REG_KEY2: key_d[127:64] = cfg_data;
			REG_KEY3: key_d[63:0] = cfg_data;
		endcase
	end

	always_comb begin
		t = win_q[7];
		if (idx_q[2:0] == 3'd0)
			t = sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'd0};
		else if (idx_q[2:0] == 3'd4)
			t = sub_word(t);
		nw = win_q[0] ^ t;
	end

	// a zero key at reset needs its schedule built too, so start busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			for (int i = 0; i < 8; i++)
				win_q[i] <= '0;
			busy_q <= 1'b1;
			idx_q <= STEP_W'(8);
			rcon_q <= RCON_INIT;
		end else if (cfg_we) begin
			key_q <= key_d;
			for (int i = 0; i < 8; i++)
				win_q[i] <= key_d[255-32*i -: 32];
			busy_q <= 1'b1;
			idx_q <= STEP_W'(8);
			rcon_q <= RCON_INIT;
		end else if (busy_q) begin
			for (int i = 0; i < 7; i++)
				win_q[i] <= win_q[i+1];
			win_q[7] <= nw;
			idx_q <= idx_q + STEP_W'(1);
			if (idx_q[2:0] == 3'd0)
				rcon_q <= xtime(rcon_q);
			if (idx_q == STEP_W'(SCHED_WORDS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 8; i++)
			w_q[i] <= key_q[255-32*i -: 32];
		if (busy_q && !cfg_we)
			w_q[idx_q] <= nw;
	end

	assign busy = busy_q;

	always_comb
		for (int r = 0; r <= ROUNDS; r++)
			round_key[r] = {w_q[4*r], w_q[4*r+1], w_q[4*r+2], w_q[4*r+3]};
endmodule

@@ design/aes_round_pipe.sv @@
// Unrolled AES round pipeline, one round per stage, stall-capable
`timescale 1ns / 1ps
module aes_round_pipe (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input aes_pkg::block_t in_data,
	input aes_pkg::block_t round_key [aes_pkg::ROUNDS+1],
	output logic out_valid,
	input logic out_ready,
	output aes_pkg::block_t out_data
);
	import aes_pkg::*;

	// stage 0 holds the whitened block, stage r the output of round r
	logic vld_s [ROUNDS+1];
	block_t dat_s [ROUNDS+1];
	logic adv [ROUNDS+1];

	assign adv[ROUNDS] = out_ready || !vld_s[ROUNDS];
	for (genvar g = ROUNDS - 1; g >= 0; g--) begin : g_adv
		assign adv[g] = adv[g+1] || !vld_s[g];
	end
	assign in_ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= ROUNDS; i++)
				vld_s[i] <= 1'b0;
		end else begin
			if (adv[0])
				vld_s[0] <= in_valid;
			for (int i = 1; i <= ROUNDS; i++)
				if (adv[i])
					vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0])
			dat_s[0] <= in_data ^ round_key[0];
		for (int i = 1; i < ROUNDS; i++)
			if (adv[i])
				dat_s[i] <= mix_columns(sub_shift(dat_s[i-1])) ^ round_key[i];
		if (adv[ROUNDS])
			dat_s[ROUNDS] <= sub_shift(dat_s[ROUNDS-1]) ^ round_key[ROUNDS];
	end

	assign out_valid = vld_s[ROUNDS];
	assign out_data = dat_s[ROUNDS];
endmodule

@@ design/aes256_block_encrypt_top.sv @@
// AES-256 encryptor top level
//
// Usage: write the 256-bit key through cfg_we/cfg_idx/cfg_data, four 64-bit
// words, index 0 holding key bytes 0..7. After a key write the schedule is
// rebuilt one word per cycle; in_ch.ready stays low meanwhile, so every
// block accepted later uses the new key. Write keys only while no block is
// in flight. Reset loads the all-zero key and builds its schedule the same
// way. Plaintext enters on in_ch, ciphertext leaves on out_ch, both
// valid/ready channels; a transaction moves one 128-bit block. The pipeline
// has 15 register stages, whitening plus 14 rounds, the first loaded at the
// accept; out_ch.valid comes from the last. The fully unrolled pipeline
// takes one block per cycle while the receiver does not stall and no
// schedule is being rebuilt. When the receiver stalls, stages hold their
// data and bubbles compress; in_ch.ready drops only when every stage is
// full or the schedule is being rebuilt. Reset clears all stage valid bits.
`timescale 1ns / 1ps
module aes256_block_encrypt_top (
	input logic clk,
	input logic arst_n,
	aes_stream_if.sink in_ch,
	aes_stream_if.source out_ch,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [63:0] cfg_data
);
	import aes_pkg::*;

	block_t rk [ROUNDS+1];
	block_t cipher;
	logic sched_busy;
	logic pipe_ready;

	aes_key_sched u_sched (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .busy(sched_busy), .round_key(rk)
	);

	aes_round_pipe u_pipe (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid && !sched_busy), .in_ready(pipe_ready),
		.in_data({in_ch.data_high, in_ch.data_low}),
		.round_key(rk),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(cipher)
	);

	assign in_ch.ready = pipe_ready && !sched_busy;
	assign out_ch.data_high = cipher[127:64];
	assign out_ch.data_low = cipher[63:0];
endmodule

@@ design/aes_checker.sv @@
// Port-level checker for the AES-256 encryptor, bound to the top level
`timescale 1ns / 1ps
`include "aes256_block_encrypt_top_defines.svh"
module aes_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [63:0] out_high,
	input logic cfg_we
);
	// a stalled result keeps its value
	`AES_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_high))
	// a key write blocks the input while the schedule is rebuilt
	`AES_ASSERT_NEXT(a_cfg_block, clk, arst_n, cfg_we, !in_ready)
	// handshake outputs are always driven
	`AES_ASSERT_IMPL(a_known, clk, arst_n, 1'b1, !$isunknown(in_ready) && !$isunknown(out_valid))
endmodule

bind aes256_block_encrypt_top aes_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_high(out_ch.data_high),
	.cfg_we(cfg_we)
);
